// ===== rtl/addressed_frame_receiver_macros.svh =====
// Assertion macros for the addressed frame receiver.
// Depends on signals named clock and reset in the module that uses them.
`ifndef ADDRESSED_FRAME_RECEIVER_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/afr_pkg.sv =====
// Package for the addressed frame receiver: parser phases, event kinds, reject causes,
// register indexes and register reset values. No dependencies.
`default_nettype none

package afr_pkg;

   // Parser phase, one per byte role in the frame
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_MODE    = 3'd1,
      PH_TARGET  = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5,
      PH_STOP    = 3'd6
   } phase_type;

   // Event kinds on the result channel
   localparam logic [1:0] EVENT_PAYLOAD  = 2'd0;
   localparam logic [1:0] EVENT_ACCEPTED = 2'd1;
   localparam logic [1:0] EVENT_REJECTED = 2'd2;

   // Reject causes
   localparam logic CAUSE_CHECKSUM = 1'b0;
   localparam logic CAUSE_STOP     = 1'b1;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_CODE     = 3'd0,
      CSR_SEND_CODE      = 3'd1,
      CSR_BROADCAST_CODE = 3'd2,
      CSR_STOP_CODE      = 3'd3,
      CSR_ACK_CODE       = 3'd4,
      CSR_RESEND_CODE    = 3'd5,
      CSR_NODE_ID        = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [7:0] RESET_START_CODE     = 8'd170;
   localparam logic [7:0] RESET_SEND_CODE      = 8'd83;
   localparam logic [7:0] RESET_BROADCAST_CODE = 8'd66;
   localparam logic [7:0] RESET_STOP_CODE      = 8'd85;
   localparam logic [7:0] RESET_ACK_CODE       = 8'd6;
   localparam logic [7:0] RESET_RESEND_CODE    = 8'd21;
   localparam logic [7:0] RESET_NODE_ID        = 8'd0;

endpackage

`default_nettype wire

// ===== rtl/addressed_frame_receiver.sv =====
// Addressed frame receiver: one byte per transfer, one parser step per byte.
// A result is registered onto rsp_ in the cycle after its byte is taken.
// Throughput: one byte per cycle unless req_stall holds it off; the parser
// state update and result register load are one compare/XOR/increment step.
// Reset (synchronous, active high): parser hunts for the start code, the
// result register is empty and all code registers take their default values.
`default_nettype none
`include "addressed_frame_receiver_macros.svh"

module addressed_frame_receiver (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // received byte channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_rx_byte,
   // event channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_event_kind,
   output logic [7:0]                               rsp_data_byte,
   output logic [7:0]                               rsp_byte_index,
   output logic                                     rsp_error_cause,
   output logic                                     rsp_reply_valid,
   output logic [7:0]                               rsp_reply_byte,
   output logic                                     rsp_is_broadcast,
   // register write port
   input  wire logic                                csr_write,
   input  wire logic [afr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                          csr_data
);
   import afr_pkg::*;

   // code registers
   logic [7:0] start_code_ff, send_code_ff, broadcast_code_ff, stop_code_ff;
   logic [7:0] ack_code_ff, resend_code_ff, node_id_ff;

   // parser state
   phase_type  phase_ff, phase_in;
   logic       broadcast_ff, broadcast_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0] running_xor_ff, running_xor_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] index_ff, index_in;
   logic       cause_ff, cause_in;
   logic       reply_valid_ff, reply_valid_in;
   logic [7:0] reply_byte_ff, reply_byte_in;
   logic       is_bcast_ff, is_bcast_in;

   logic       emit;
   logic       req_take;
   logic [7:0] bytes_next;

   // input is held off only while a result waits and cannot drain
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff     <= RESET_START_CODE;
         send_code_ff      <= RESET_SEND_CODE;
         broadcast_code_ff <= RESET_BROADCAST_CODE;
         stop_code_ff      <= RESET_STOP_CODE;
         ack_code_ff       <= RESET_ACK_CODE;
         resend_code_ff    <= RESET_RESEND_CODE;
         node_id_ff        <= RESET_NODE_ID;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_CODE:     start_code_ff     <= csr_data;
            CSR_SEND_CODE:      send_code_ff      <= csr_data;
            CSR_BROADCAST_CODE: broadcast_code_ff <= csr_data;
            CSR_STOP_CODE:      stop_code_ff      <= csr_data;
            CSR_ACK_CODE:       ack_code_ff       <= csr_data;
            CSR_RESEND_CODE:    resend_code_ff    <= csr_data;
            CSR_NODE_ID:        node_id_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   assign bytes_next = bytes_seen_ff + 8'd1;

   // parser next state and result for the byte on req_
   always_comb begin
      phase_in        = phase_ff;
      broadcast_in    = broadcast_ff;
      frame_length_in = frame_length_ff;
      bytes_seen_in   = bytes_seen_ff;
      running_xor_in  = running_xor_ff;
      emit            = 1'b0;
      kind_in         = EVENT_PAYLOAD;
      data_in         = 8'd0;
      index_in        = 8'd0;
      cause_in        = CAUSE_CHECKSUM;
      reply_valid_in  = 1'b0;
      reply_byte_in   = 8'd0;
      is_bcast_in     = broadcast_ff;

      unique case (phase_ff)
         PH_MODE: begin
            broadcast_in = (req_rx_byte == broadcast_code_ff);
            phase_in     = (req_rx_byte == send_code_ff) ? PH_TARGET : PH_LENGTH;
         end
         PH_TARGET: begin
            phase_in = (req_rx_byte == node_id_ff) ? PH_LENGTH : PH_HUNT;
         end
         PH_LENGTH: begin
            frame_length_in = req_rx_byte;
            bytes_seen_in   = 8'd0;
            running_xor_in  = 8'd0;
            phase_in        = (req_rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            running_xor_in = running_xor_ff ^ req_rx_byte;
            bytes_seen_in  = bytes_next;
            if (bytes_next == frame_length_ff) begin
               phase_in = PH_CHECK;
            end
            emit     = 1'b1;
            kind_in  = EVENT_PAYLOAD;
            data_in  = req_rx_byte;
            index_in = bytes_seen_ff;
         end
         PH_CHECK: begin
            if (req_rx_byte != running_xor_ff) begin
               phase_in       = PH_HUNT;
               emit           = 1'b1;
               kind_in        = EVENT_REJECTED;
               cause_in       = CAUSE_CHECKSUM;
               reply_valid_in = ~broadcast_ff;
               reply_byte_in  = broadcast_ff ? 8'd0 : resend_code_ff;
            end else begin
               phase_in = PH_STOP;
            end
         end
         PH_STOP: begin
            phase_in       = PH_HUNT;
            emit           = 1'b1;
            reply_valid_in = ~broadcast_ff;
            if (req_rx_byte != stop_code_ff) begin
               kind_in       = EVENT_REJECTED;
               cause_in      = CAUSE_STOP;
               reply_byte_in = broadcast_ff ? 8'd0 : resend_code_ff;
            end else begin
               kind_in       = EVENT_ACCEPTED;
               data_in       = frame_length_ff;
               reply_byte_in = broadcast_ff ? 8'd0 : ack_code_ff;
            end
         end
         // hunting, and any unused phase code
         default: begin
            phase_in = (req_rx_byte == start_code_ff) ? PH_MODE : PH_HUNT;
         end
      endcase
   end

   // result register occupancy
   always_comb begin
      priority if (req_take) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // parser state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         broadcast_ff    <= 1'b0;
         frame_length_ff <= 8'd0;
         bytes_seen_ff   <= 8'd0;
         running_xor_ff  <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            phase_ff        <= phase_in;
            broadcast_ff    <= broadcast_in;
            frame_length_ff <= frame_length_in;
            bytes_seen_ff   <= bytes_seen_in;
            running_xor_ff  <= running_xor_in;
         end
      end
   end

   // result payload, loaded on a transfer that emits
   always_ff @(posedge clock) begin
      if (req_take && emit) begin
         kind_ff        <= kind_in;
         data_ff        <= data_in;
         index_ff       <= index_in;
         cause_ff       <= cause_in;
         reply_valid_ff <= reply_valid_in;
         reply_byte_ff  <= reply_byte_in;
         is_bcast_ff    <= is_bcast_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_error_cause  = cause_ff;
   assign rsp_reply_valid  = reply_valid_ff;
   assign rsp_reply_byte   = reply_byte_ff;
   assign rsp_is_broadcast = is_bcast_ff;

   // checks on parser and result register
   `AFR_ASSERT_SAME(a_check_count, phase_ff == PH_CHECK, bytes_seen_ff == frame_length_ff, "checksum phase with payload count off")
   `AFR_ASSERT_NEXT(a_payload_emits, req_take && phase_ff == PH_PAYLOAD, rsp_valid_ff && kind_ff == EVENT_PAYLOAD, "payload byte did not produce an event")
   `AFR_ASSERT_SAME(a_reply_kind, rsp_valid_ff && reply_valid_ff, kind_ff != EVENT_PAYLOAD && !is_bcast_ff, "reply on payload or broadcast event")
   `AFR_ASSERT_SAME(a_stall_full, req_stall, rsp_valid_ff, "input held off with empty result register")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the addressed frame receiver: byte stream stimulus, a frame parser
// model that predicts every event, and a field-by-field check of the event channel.
// Depends on afr_pkg and addressed_frame_receiver from the rtl folder.
`timescale 1ns / 100ps

module tb_top;
   import afr_pkg::*;

   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 8;     // covers the result register, plus margin
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] byte_index;
      logic       cause;
      logic       reply_valid;
      logic [7:0] reply;
      logic       broadcast;
   } frame_event_type;

   // DUT ports
   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   logic [7:0]    req_rx_byte = 8'h00;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   logic [1:0]    rsp_event_kind;
   logic [7:0]    rsp_data_byte;
   logic [7:0]    rsp_byte_index;
   logic          rsp_error_cause;
   logic          rsp_reply_valid;
   logic [7:0]    rsp_reply_byte;
   logic          rsp_is_broadcast;
   logic          csr_write   = 1'b0;
   csr_index_type csr_index   = CSR_START_CODE;
   logic [7:0]    csr_data    = 8'h00;

   // Frame parser model: code registers and parse state
   logic [7:0]      code_reg [0:6];
   phase_type       parse_phase;
   logic            frame_is_broadcast;
   logic [7:0]      frame_len;
   logic [7:0]      payload_count;
   logic [7:0]      payload_xor;
   frame_event_type pending_events [$];
   frame_event_type due_event;

   // Run control and bookkeeping
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_start         = 1'b0;
   int hold_left          = 0;
   int bytes_sent         = 0;
   int settings_applied   = 0;
   int payload_seen       = 0;
   int accepted_seen      = 0;
   int rejected_seen      = 0;
   int error_count        = 0;

   addressed_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_error_cause  (rsp_error_cause),
      .rsp_reply_valid  (rsp_reply_valid),
      .rsp_reply_byte   (rsp_reply_byte),
      .rsp_is_broadcast (rsp_is_broadcast),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   // End-of-frame event; the reply byte goes out only for non-broadcast frames
   function automatic frame_event_type frame_end_event(input logic [1:0] kind,
         input logic [7:0] data, input logic cause, input logic [7:0] reply_code);
      frame_event_type ev;
      ev = '0;
      ev.kind        = kind;
      ev.data        = data;
      ev.cause       = cause;
      ev.reply_valid = !frame_is_broadcast;
      ev.reply       = frame_is_broadcast ? 8'h00 : reply_code;
      ev.broadcast   = frame_is_broadcast;
      return ev;
   endfunction

   // One parser step per accepted byte; queues the event it causes, if any
   task automatic parse_rx_byte(input logic [7:0] rx);
      frame_event_type ev;
      case (parse_phase)
         PH_MODE: begin
            frame_is_broadcast = (rx == code_reg[CSR_BROADCAST_CODE]);
            parse_phase = (rx == code_reg[CSR_SEND_CODE]) ? PH_TARGET : PH_LENGTH;
         end
         PH_TARGET: parse_phase = (rx == code_reg[CSR_NODE_ID]) ? PH_LENGTH : PH_HUNT;
         PH_LENGTH: begin
            frame_len     = rx;
            payload_count = 8'd0;
            payload_xor   = 8'd0;
            // empty payload goes straight to the checksum byte
            parse_phase   = (rx == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            ev = '0;
            ev.kind       = EVENT_PAYLOAD;
            ev.data       = rx;
            ev.byte_index = payload_count;
            ev.broadcast  = frame_is_broadcast;
            pending_events.push_back(ev);
            payload_xor   = payload_xor ^ rx;
            payload_count = payload_count + 8'd1;
            if (payload_count == frame_len) parse_phase = PH_CHECK;
         end
         PH_CHECK: begin
            // bad checksum rejects at once, no stop byte is read
            if (rx != payload_xor) begin
               parse_phase = PH_HUNT;
               pending_events.push_back(frame_end_event(EVENT_REJECTED, 8'h00,
                  CAUSE_CHECKSUM, code_reg[CSR_RESEND_CODE]));
            end else begin
               parse_phase = PH_STOP;
            end
         end
         PH_STOP: begin
            parse_phase = PH_HUNT;
            if (rx != code_reg[CSR_STOP_CODE])
               pending_events.push_back(frame_end_event(EVENT_REJECTED, 8'h00,
                  CAUSE_STOP, code_reg[CSR_RESEND_CODE]));
            else
               pending_events.push_back(frame_end_event(EVENT_ACCEPTED, frame_len,
                  1'b0, code_reg[CSR_ACK_CODE]));
         end
         default: parse_phase = (rx == code_reg[CSR_START_CODE]) ? PH_MODE : PH_HUNT;
      endcase
   endtask

   // Drive one byte, with random idle cycles ahead of it, and wait for its transfer
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      parse_rx_byte(value);
      bytes_sent++;
   endtask

   // Register writes only happen once every queued event has come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_register(input csr_index_type idx, input logic [7:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      code_reg[idx] = value;
   endtask

   task automatic write_one(input csr_index_type idx, input logic [7:0] value);
      wait_idle();
      put_register(idx, value);
      csr_write <= 1'b0;
   endtask

   task automatic write_codes(input logic [7:0] start_v, input logic [7:0] send_v,
         input logic [7:0] bcast_v, input logic [7:0] stop_v, input logic [7:0] ack_v,
         input logic [7:0] resend_v, input logic [7:0] node_v);
      wait_idle();
      put_register(CSR_START_CODE, start_v);
      put_register(CSR_SEND_CODE, send_v);
      put_register(CSR_BROADCAST_CODE, bcast_v);
      put_register(CSR_STOP_CODE, stop_v);
      put_register(CSR_ACK_CODE, ack_v);
      put_register(CSR_RESEND_CODE, resend_v);
      put_register(CSR_NODE_ID, node_v);
      csr_write <= 1'b0;
      settings_applied++;
   endtask

   // Whole frame from the current codes; extremes alternates 0x00 / 0xFF payload
   task automatic send_frame(input logic [7:0] mode, input logic [7:0] target,
         input logic [7:0] len, input bit extremes, input bit bad_sum, input bit bad_stop);
      logic [7:0] sum;
      logic [7:0] value;
      int         i;
      sum = 8'h00;
      send_byte(code_reg[CSR_START_CODE]);
      send_byte(mode);
      if (mode == code_reg[CSR_SEND_CODE]) begin
         send_byte(target);
         if (target != code_reg[CSR_NODE_ID]) return;
      end
      send_byte(len);
      for (i = 0; i < len; i++) begin
         value = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
         sum   = sum ^ value;
         send_byte(value);
      end
      if (bad_sum) begin
         send_byte(sum ^ 8'($urandom_range(1, 255)));
         return;
      end
      send_byte(sum);
      if (bad_stop)
         send_byte(code_reg[CSR_STOP_CODE] ^ 8'($urandom_range(1, 255)));
      else
         send_byte(code_reg[CSR_STOP_CODE]);
   endtask

   // Mostly well-formed frames, with broken ones and line noise mixed in
   task automatic send_random_frame();
      int         pick;
      int         n;
      logic [7:0] mode;
      logic [7:0] target;
      logic [7:0] len;
      pick = $urandom_range(99);
      if (pick < 5) begin
         n = $urandom_range(1, 6);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(2))
         0:       mode = code_reg[CSR_SEND_CODE];
         1:       mode = code_reg[CSR_BROADCAST_CODE];
         default: mode = 8'($urandom_range(0, 255));
      endcase
      target = code_reg[CSR_NODE_ID];
      if (pick < 10) target = target ^ 8'($urandom_range(1, 255));
      // rare long payloads, the rest short
      len = ($urandom_range(99) == 0) ? 8'($urandom_range(200, 255))
                                      : 8'($urandom_range(0, 8));
      send_frame(mode, target, len, 1'b0, pick >= 10 && pick < 20, pick >= 20 && pick < 30);
   endtask

   task automatic run_random_frames(input int n);
      int stop_at;
      stop_at = bytes_sent + n;
      while (bytes_sent < stop_at) send_random_frame();
   endtask

   task automatic write_random_codes();
      write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_frames();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // addressed frame, empty payload: checksum byte is zero
      send_frame(code_reg[CSR_SEND_CODE], code_reg[CSR_NODE_ID], 8'd0, 1'b1, 1'b0, 1'b0);
      // broadcast with payload at both extremes, no reply byte
      send_frame(code_reg[CSR_BROADCAST_CODE], 8'h00, 8'd2, 1'b1, 1'b0, 1'b0);
      // plain mode, no target byte, checksum mismatch
      send_frame(8'hFF, 8'h00, 8'd1, 1'b1, 1'b1, 1'b0);
      // plain mode closed by a wrong stop code
      send_frame(8'h00, 8'h00, 8'd1, 1'b0, 1'b0, 1'b1);
      // addressed to another node: dropped silently
      send_frame(code_reg[CSR_SEND_CODE], 8'hFF, 8'd3, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_code_extremes();
      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      // all codes zero: mode zero is send and broadcast at the same time
      write_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_frame(8'h00, 8'h00, 8'd2, 1'b0, 1'b0, 1'b0);
      run_random_frames(150);
      write_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_frame(8'hFF, 8'hFF, 8'd1, 1'b1, 1'b0, 1'b0);
      run_random_frames(150);
   endtask

   task automatic test_sender_gaps();
      write_random_codes();
      sender_idle_pct    = 60;
      receiver_stall_pct = 0;
      run_random_frames(300);
   endtask

   task automatic test_receiver_stalls();
      write_random_codes();
      sender_idle_pct    = 0;
      receiver_stall_pct = 60;
      run_random_frames(300);
   endtask

   task automatic test_mixed_idling();
      write_random_codes();
      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      run_random_frames(300);
   endtask

   task automatic test_full_rate();
      write_codes(RESET_START_CODE, RESET_SEND_CODE, RESET_BROADCAST_CODE, RESET_STOP_CODE,
         RESET_ACK_CODE, RESET_RESEND_CODE, RESET_NODE_ID);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random_frames(300);
   endtask

   // Codes change while the parser sits inside a frame
   task automatic test_midframe_writes();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // new send code is used for the mode byte, so a target byte follows
      send_byte(code_reg[CSR_START_CODE]);
      write_one(CSR_SEND_CODE, code_reg[CSR_SEND_CODE] + 8'd1);
      send_byte(code_reg[CSR_SEND_CODE]);
      send_byte(code_reg[CSR_NODE_ID]);
      send_byte(8'd1);
      send_byte(8'h5A);
      send_byte(8'h5A);
      send_byte(code_reg[CSR_STOP_CODE]);
      // broadcast is latched at the mode byte; stop code is read when it arrives
      send_byte(code_reg[CSR_START_CODE]);
      send_byte(code_reg[CSR_BROADCAST_CODE]);
      write_one(CSR_BROADCAST_CODE, ~code_reg[CSR_BROADCAST_CODE]);
      send_byte(8'd1);
      send_byte(8'hA5);
      send_byte(8'hA5);
      write_one(CSR_STOP_CODE, ~code_reg[CSR_STOP_CODE]);
      send_byte(code_reg[CSR_STOP_CODE]);
   endtask

   // Output held off for a long stretch while bytes keep coming
   task automatic test_output_hold_off();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // last byte has transferred; drop valid so it is not taken again
      req_valid <= 1'b0;
      @(negedge clock);
      hold_start = 1'b1;
      @(posedge clock);
      send_frame(code_reg[CSR_BROADCAST_CODE], 8'h00, 8'd40, 1'b0, 1'b0, 1'b0);
      run_random_frames(60);
   endtask

   // ---------------------------------------------------------------- processes

   // Event channel stall: random, or held high for a counted stretch
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Signals are stable mid-cycle; a transfer seen here completes at the next edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event: expected none, actual kind %0d data %0d",
               $time, rsp_event_kind, rsp_data_byte);
            error_count++;
         end else begin
            due_event = pending_events.pop_front();
            check_field("event_kind", 8'(due_event.kind), 8'(rsp_event_kind));
            check_field("data_byte", due_event.data, rsp_data_byte);
            check_field("byte_index", due_event.byte_index, rsp_byte_index);
            check_field("error_cause", 8'(due_event.cause), 8'(rsp_error_cause));
            check_field("reply_valid", 8'(due_event.reply_valid), 8'(rsp_reply_valid));
            check_field("reply_byte", due_event.reply, rsp_reply_byte);
            check_field("is_broadcast", 8'(due_event.broadcast), 8'(rsp_is_broadcast));
            case (due_event.kind)
               EVENT_PAYLOAD:  payload_seen++;
               EVENT_ACCEPTED: accepted_seen++;
               default:        rejected_seen++;
            endcase
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no transfer for %0d cycles, %0d events outstanding",
         $time, WATCHDOG_LIMIT, pending_events.size());
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      // model starts from the reset state of the block
      code_reg[CSR_START_CODE]     = RESET_START_CODE;
      code_reg[CSR_SEND_CODE]      = RESET_SEND_CODE;
      code_reg[CSR_BROADCAST_CODE] = RESET_BROADCAST_CODE;
      code_reg[CSR_STOP_CODE]      = RESET_STOP_CODE;
      code_reg[CSR_ACK_CODE]       = RESET_ACK_CODE;
      code_reg[CSR_RESEND_CODE]    = RESET_RESEND_CODE;
      code_reg[CSR_NODE_ID]        = RESET_NODE_ID;
      parse_phase        = PH_HUNT;
      frame_is_broadcast = 1'b0;
      frame_len          = 8'd0;
      payload_count      = 8'd0;
      payload_xor        = 8'd0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_code_extremes();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_full_rate();
      test_midframe_writes();
      test_output_hold_off();

      // drain: wait until every queued event is out, plus a quiet margin
      wait_idle();
      if (pending_events.size() != 0) begin
         $display("%0t: events left over: expected 0, actual %0d", $time,
            pending_events.size());
         error_count++;
      end

      $display("tb_top: %0d bytes sent across %0d code settings, four idling mixes and a hold-off",
         bytes_sent, settings_applied);
      $display("tb_top: checked %0d payload bytes, %0d accepted and %0d rejected frames",
         payload_seen, accepted_seen, rejected_seen);
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
